FILE: design/wspr_pkg.sv
// Shared types and constants for the WSP Reply PDU parser.
// No dependencies; imported by wspr_parser, wspr_rsp_queue and wsp_reply_pdu_parser.
package wspr_pkg;

   // Kind of a result beat.
   typedef enum logic [3:0] {
      KIND_STATUS    = 4'd0,
      KIND_TYPE_CODE = 4'd1,
      KIND_TYPE_CHAR = 4'd2,
      KIND_SERVER    = 4'd3,
      KIND_LOCATION  = 4'd4,
      KIND_LENGTH    = 4'd5,
      KIND_BODY      = 4'd6,
      KIND_DONE      = 4'd7,
      KIND_ERROR     = 4'd8
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_SHORT     = 2'd1,
      ERR_NOT_REPLY = 2'd2,
      ERR_BAD_UVAR  = 2'd3
   } err_type;

   localparam logic [7:0] TYPE_REPLY      = 8'h04;
   localparam logic [7:0] TEXT_MIN        = 8'h20;
   localparam logic [7:0] SHORT_LEN_LIMIT = 8'd31;
   localparam logic [6:0] HDR_SERVER      = 7'h26;
   localparam logic [6:0] HDR_LOCATION    = 7'h1C;
   localparam logic [6:0] HDR_CONT_LEN    = 7'h0D;
   localparam logic [2:0] UVAR_MAX_BYTES  = 3'd5;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] value;
      logic        string_end;
      logic [15:0] body_length;
      logic        headers_truncated;
      err_type     error_code;
      logic        pdu_end;
   } rsp_item_type;

   // Up to two result beats produced by one input byte, in order.
   typedef struct packed {
      logic         vld0;
      rsp_item_type item0;
      logic         vld1;
      rsp_item_type item1;
   } push_type;

   function automatic rsp_item_type make_item(input kind_type k, input logic [31:0] v,
                                              input logic send, input logic [15:0] blen,
                                              input logic trunc, input err_type e,
                                              input logic last);
      rsp_item_type it;
      it.kind              = k;
      it.value             = v;
      it.string_end        = send;
      it.body_length       = blen;
      it.headers_truncated = trunc;
      it.error_code        = e;
      it.pdu_end           = last;
      return it;
   endfunction

endpackage

FILE: design/wspr_parser.sv
// Byte-wise parse state machine of the WSP Reply PDU parser.
// Depends on wspr_pkg; produces up to two result beats per consumed byte.
module wspr_parser #(
   parameter int PDU_LENGTH_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              tid_present,
   input  logic              go,
   input  logic [7:0]        data_byte,
   input  logic              final_byte,
   output wspr_pkg::push_type push
);
   import wspr_pkg::*;

   typedef enum logic [20:0] {
      PH_TID           = 21'h000001,
      PH_TYPE          = 21'h000002,
      PH_STATUS        = 21'h000004,
      PH_UVAR          = 21'h000008,
      PH_CT_FIRST      = 21'h000010,
      PH_CT_LENVAL     = 21'h000020,
      PH_CT_TEXT       = 21'h000040,
      PH_FIELD         = 21'h000080,
      PH_NAME_SKIP     = 21'h000100,
      PH_NAMEVAL_FIRST = 21'h000200,
      PH_TEXT_SKIP     = 21'h000400,
      PH_SRV_FIRST     = 21'h000800,
      PH_SRV_TEXT      = 21'h001000,
      PH_LOC_FIRST     = 21'h002000,
      PH_LOC_TEXT      = 21'h004000,
      PH_CL_FIRST      = 21'h008000,
      PH_CL_MULTI      = 21'h010000,
      PH_OTH_FIRST     = 21'h020000,
      PH_SKIP          = 21'h040000,
      PH_BODY          = 21'h080000,
      PH_DISCARD       = 21'h100000
   } phase_type;

   localparam logic [PDU_LENGTH_BITS-1:0] COUNT_MAX = {PDU_LENGTH_BITS{1'b1}};

   phase_type                  phase_ff, phase_in;
   logic                       started_ff, started_in;
   logic [31:0]                hdr_rem_ff, hdr_rem_in;
   logic [4:0]                 skip_ff, skip_in;
   logic [31:0]                acc_ff, acc_in;
   logic [2:0]                 uvb_ff, uvb_in;
   logic [31:0]                clen_ff, clen_in;
   logic [PDU_LENGTH_BITS-1:0] body_cnt_ff, body_cnt_in;

   // Phase that follows the first byte of a header field.
   function automatic phase_type field_next(input logic [7:0] b);
      phase_type p;
      if (b[7]) begin
         if (b[6:0] == HDR_SERVER) p = PH_SRV_FIRST;
         else if (b[6:0] == HDR_LOCATION) p = PH_LOC_FIRST;
         else if (b[6:0] == HDR_CONT_LEN) p = PH_CL_FIRST;
         else p = PH_OTH_FIRST;
      end else if (b < TEXT_MIN) begin
         p = PH_FIELD;
      end else begin
         p = PH_NAME_SKIP;
      end
      return p;
   endfunction

   always_comb begin
      phase_type    cur;
      logic         main_v, len_v, done_v, trunc;
      rsp_item_type main_it, len_it, done_it, blank;
      logic [31:0]  bval, bc_wide, hr_dec;

      blank   = make_item(KIND_STATUS, 32'd0, 1'b0, 16'd0, 1'b0, ERR_NONE, 1'b0);
      cur     = started_ff ? phase_ff : (tid_present ? PH_TID : PH_TYPE);
      bval    = {24'd0, data_byte};
      main_v  = 1'b0;
      len_v   = 1'b0;
      done_v  = 1'b0;
      trunc   = 1'b0;
      main_it = blank;
      len_it  = blank;
      done_it = blank;
      hr_dec  = hdr_rem_ff - 32'd1;
      bc_wide = 32'd0;

      phase_in    = cur;
      started_in  = 1'b1;
      hdr_rem_in  = hdr_rem_ff;
      skip_in     = skip_ff;
      acc_in      = acc_ff;
      uvb_in      = uvb_ff;
      clen_in     = clen_ff;
      body_cnt_in = body_cnt_ff;

      case (cur)
         PH_TID, PH_TYPE, PH_STATUS: begin
            if (final_byte) begin
               main_v  = 1'b1;
               main_it = make_item(KIND_ERROR, 32'd0, 1'b0, 16'd0, 1'b0, ERR_SHORT, 1'b1);
            end else if (cur == PH_TID) begin
               phase_in = PH_TYPE;
            end else if (cur == PH_TYPE) begin
               if (data_byte != TYPE_REPLY) begin
                  main_v   = 1'b1;
                  main_it  = make_item(KIND_ERROR, 32'd0, 1'b0, 16'd0, 1'b0,
                                       ERR_NOT_REPLY, 1'b1);
                  phase_in = PH_DISCARD;
               end else begin
                  phase_in = PH_STATUS;
               end
            end else begin
               main_v   = 1'b1;
               main_it  = make_item(KIND_STATUS, bval, 1'b0, 16'd0, 1'b0, ERR_NONE, 1'b0);
               acc_in   = 32'd0;
               uvb_in   = 3'd0;
               phase_in = PH_UVAR;
            end
         end
         PH_UVAR: begin
            acc_in = {acc_ff[24:0], data_byte[6:0]};
            uvb_in = uvb_ff + 3'd1;
            if (!data_byte[7]) begin
               hdr_rem_in = acc_in;
               phase_in   = (acc_in == 32'd0) ? PH_BODY : PH_CT_FIRST;
               acc_in     = 32'd0;
            end else if (final_byte || uvb_in >= UVAR_MAX_BYTES) begin
               main_v  = 1'b1;
               main_it = make_item(KIND_ERROR, 32'd0, 1'b0, 16'd0, 1'b0, ERR_BAD_UVAR, 1'b1);
               if (!final_byte) phase_in = PH_DISCARD;
            end
         end
         PH_BODY: begin
            main_v  = 1'b1;
            main_it = make_item(KIND_BODY, bval, 1'b0, 16'd0, 1'b0, ERR_NONE, 1'b0);
            if (body_cnt_ff != COUNT_MAX) body_cnt_in = body_cnt_ff + 1'b1;
         end
         PH_DISCARD: begin
            phase_in = PH_DISCARD;
         end
         default: begin
            // Header block byte.
            hdr_rem_in = hr_dec;
            case (cur)
               PH_CT_FIRST: begin
                  if (data_byte[7]) begin
                     main_v   = 1'b1;
                     main_it  = make_item(KIND_TYPE_CODE, {25'd0, data_byte[6:0]}, 1'b0,
                                          16'd0, 1'b0, ERR_NONE, 1'b0);
                     phase_in = PH_FIELD;
                  end else if (data_byte < TEXT_MIN) begin
                     skip_in  = data_byte[4:0];
                     phase_in = PH_CT_LENVAL;
                  end else begin
                     main_v   = 1'b1;
                     main_it  = make_item(KIND_TYPE_CHAR, bval, 1'b0, 16'd0, 1'b0,
                                          ERR_NONE, 1'b0);
                     phase_in = PH_CT_TEXT;
                  end
               end
               PH_CT_LENVAL: begin
                  if (data_byte[7]) begin
                     main_v  = 1'b1;
                     main_it = make_item(KIND_TYPE_CODE, {25'd0, data_byte[6:0]}, 1'b0,
                                         16'd0, 1'b0, ERR_NONE, 1'b0);
                  end
                  if (skip_ff == 5'd0) begin
                     phase_in = field_next(data_byte);
                  end else begin
                     skip_in  = skip_ff - 5'd1;
                     phase_in = (skip_in == 5'd0) ? PH_FIELD : PH_SKIP;
                  end
               end
               PH_CT_TEXT, PH_SRV_TEXT, PH_LOC_TEXT, PH_SRV_FIRST, PH_LOC_FIRST: begin
                  if ((cur == PH_SRV_FIRST || cur == PH_LOC_FIRST) && data_byte[7]) begin
                     phase_in = PH_FIELD;
                  end else begin
                     main_v = 1'b1;
                     if (cur == PH_CT_TEXT) main_it.kind = KIND_TYPE_CHAR;
                     else if (cur == PH_SRV_TEXT || cur == PH_SRV_FIRST)
                        main_it.kind = KIND_SERVER;
                     else main_it.kind = KIND_LOCATION;
                     if (data_byte == 8'd0) begin
                        main_it.string_end = 1'b1;
                        phase_in           = PH_FIELD;
                     end else begin
                        main_it.value = bval;
                        if (cur == PH_CT_TEXT) phase_in = PH_CT_TEXT;
                        else if (cur == PH_SRV_TEXT || cur == PH_SRV_FIRST)
                           phase_in = PH_SRV_TEXT;
                        else phase_in = PH_LOC_TEXT;
                     end
                  end
               end
               PH_FIELD: begin
                  phase_in = field_next(data_byte);
               end
               PH_NAME_SKIP: begin
                  if (data_byte == 8'd0) phase_in = PH_NAMEVAL_FIRST;
               end
               PH_NAMEVAL_FIRST: begin
                  phase_in = (data_byte[7] || data_byte == 8'd0) ? PH_FIELD : PH_TEXT_SKIP;
               end
               PH_TEXT_SKIP: begin
                  if (data_byte == 8'd0) phase_in = PH_FIELD;
               end
               PH_CL_FIRST: begin
                  if (data_byte[7]) begin
                     clen_in  = {25'd0, data_byte[6:0]};
                     main_v   = 1'b1;
                     main_it  = make_item(KIND_LENGTH, clen_in, 1'b0, 16'd0, 1'b0,
                                          ERR_NONE, 1'b0);
                     phase_in = PH_FIELD;
                  end else if (data_byte < SHORT_LEN_LIMIT) begin
                     acc_in  = 32'd0;
                     skip_in = data_byte[4:0];
                     if (data_byte == 8'd0) begin
                        clen_in  = 32'd0;
                        main_v   = 1'b1;
                        main_it  = make_item(KIND_LENGTH, 32'd0, 1'b0, 16'd0, 1'b0,
                                             ERR_NONE, 1'b0);
                        phase_in = PH_FIELD;
                     end else begin
                        phase_in = PH_CL_MULTI;
                     end
                  end else begin
                     phase_in = PH_FIELD;
                  end
               end
               PH_CL_MULTI: begin
                  acc_in  = {acc_ff[23:0], data_byte};
                  skip_in = skip_ff - 5'd1;
                  if (skip_in == 5'd0) begin
                     clen_in  = acc_in;
                     main_v   = 1'b1;
                     main_it  = make_item(KIND_LENGTH, acc_in, 1'b0, 16'd0, 1'b0,
                                          ERR_NONE, 1'b0);
                     phase_in = PH_FIELD;
                  end
               end
               PH_OTH_FIRST: begin
                  if (data_byte[7]) begin
                     phase_in = PH_FIELD;
                  end else if (data_byte < SHORT_LEN_LIMIT) begin
                     skip_in  = data_byte[4:0];
                     phase_in = (data_byte == 8'd0) ? PH_FIELD : PH_SKIP;
                  end else begin
                     phase_in = PH_TEXT_SKIP;
                  end
               end
               PH_SKIP: begin
                  if (skip_ff != 5'd0) skip_in = skip_ff - 5'd1;
                  if (skip_in == 5'd0) phase_in = PH_FIELD;
               end
               default: begin
                  phase_in = PH_FIELD;
               end
            endcase
            // End of the header block: flush a cut-off multi-octet length.
            if (hr_dec == 32'd0) begin
               if (phase_in == PH_CL_MULTI) begin
                  clen_in = acc_in;
                  len_v   = 1'b1;
                  len_it  = make_item(KIND_LENGTH, acc_in, 1'b0, 16'd0, 1'b0, ERR_NONE, 1'b0);
               end
               phase_in = PH_BODY;
            end
         end
      endcase

      if (final_byte) begin
         if (phase_in != PH_TID && phase_in != PH_TYPE && phase_in != PH_STATUS &&
             phase_in != PH_UVAR && phase_in != PH_DISCARD) begin
            if (phase_in != PH_BODY) begin
               trunc = 1'b1;
               if (phase_in == PH_CL_MULTI) begin
                  clen_in = acc_in;
                  len_v   = 1'b1;
                  len_it  = make_item(KIND_LENGTH, acc_in, 1'b0, 16'd0, 1'b0, ERR_NONE, 1'b0);
               end
            end
            bc_wide = 32'(body_cnt_in);
            done_v  = 1'b1;
            done_it = make_item(KIND_DONE, (clen_in != 32'd0) ? clen_in : bc_wide, 1'b0,
                                bc_wide[15:0], trunc, ERR_NONE, 1'b1);
         end
         // Per-PDU state is cleared after the last byte.
         started_in  = 1'b0;
         phase_in    = PH_TYPE;
         hdr_rem_in  = 32'd0;
         skip_in     = 5'd0;
         acc_in      = 32'd0;
         uvb_in      = 3'd0;
         clen_in     = 32'd0;
         body_cnt_in = '0;
      end

      // Order the beats: byte result, flushed length, then done.
      push.vld0  = 1'b0;
      push.item0 = blank;
      push.vld1  = 1'b0;
      push.item1 = blank;
      if (main_v) begin
         push.vld0  = go;
         push.item0 = main_it;
         if (len_v) begin
            push.vld1  = go;
            push.item1 = len_it;
         end else if (done_v) begin
            push.vld1  = go;
            push.item1 = done_it;
         end
      end else if (len_v) begin
         push.vld0  = go;
         push.item0 = len_it;
         if (done_v) begin
            push.vld1  = go;
            push.item1 = done_it;
         end
      end else if (done_v) begin
         push.vld0  = go;
         push.item0 = done_it;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TYPE;
         started_ff  <= 1'b0;
         hdr_rem_ff  <= 32'd0;
         skip_ff     <= 5'd0;
         acc_ff      <= 32'd0;
         uvb_ff      <= 3'd0;
         clen_ff     <= 32'd0;
         body_cnt_ff <= '0;
      end else if (go) begin
         phase_ff    <= phase_in;
         started_ff  <= started_in;
         hdr_rem_ff  <= hdr_rem_in;
         skip_ff     <= skip_in;
         acc_ff      <= acc_in;
         uvb_ff      <= uvb_in;
         clen_ff     <= clen_in;
         body_cnt_ff <= body_cnt_in;
      end
   end

endmodule

FILE: design/wspr_rsp_queue.sv
// Four-entry result queue of the WSP Reply PDU parser: two pushes, one pop per cycle.
// Depends on wspr_pkg for the result beat and push group types.
module wspr_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  wspr_pkg::push_type     push,
   input  logic                   pop_ready,
   output logic                   out_vld,
   output wspr_pkg::rsp_item_type out_item,
   output logic                   room
);
   import wspr_pkg::*;

   localparam int DEPTH  = 4;
   localparam int CNT_W  = $clog2(DEPTH + 1);

   rsp_item_type          q_ff [DEPTH];
   rsp_item_type          q_in [DEPTH];
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      base;
   logic                  pop;

   assign out_vld  = (cnt_ff != '0);
   assign out_item = q_ff[0];
   assign pop      = out_vld && pop_ready;
   assign base     = cnt_ff - CNT_W'(pop);
   // Room for two more beats once this cycle's pop is taken.
   assign room     = (base <= CNT_W'(DEPTH - 2));

   always_comb begin
      for (int i = 0; i < DEPTH - 1; i++) begin
         q_in[i] = pop ? q_ff[i + 1] : q_ff[i];
      end
      q_in[DEPTH-1] = q_ff[DEPTH-1];
      for (int i = 0; i < DEPTH; i++) begin
         if (push.vld0 && base == CNT_W'(i)) q_in[i] = push.item0;
         if (push.vld1 && base + CNT_W'(1) == CNT_W'(i)) q_in[i] = push.item1;
      end
      cnt_in = base + CNT_W'(push.vld0) + CNT_W'(push.vld1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

endmodule

FILE: design/wsp_reply_pdu_parser.sv
// A byte accepted into the input register is parsed when the result queue has room; its result
// beats are written into the result queue, from which the downstream side takes them.
// Throughput: one byte per cycle while the result queue has room; a byte may yield two result
// beats, and the four-entry result queue absorbs such bursts.
// Reset (synchronous, active high) empties the input register and the result queue, sets
// tid_present to 1 and returns the parser to the start of a PDU.
// Top level of the WSP Reply PDU parser; depends on wspr_pkg, wspr_parser and wspr_rsp_queue.
module wsp_reply_pdu_parser #(
   parameter int PDU_LENGTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input bytes.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tlast,   // final_byte
   // Result beats.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // value[31:0], string_end[32], body_length[48:33], headers_truncated[49],
   // error_code[51:50], zero pad[55:52]
   output logic [55:0] rsp_tdata,
   output logic [3:0]  rsp_tuser,   // kind[3:0]
   output logic        rsp_tlast,   // pdu_end
   // Configuration: tid_present.
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import wspr_pkg::*;

   // The input register holds one byte; it is consumed whenever the result queue has room
   // for the up to two beats the byte may produce, so a new byte is taken in the same cycle.
   logic         in_vld_ff, in_vld_in;
   logic [7:0]   in_data_ff;
   logic         in_last_ff;
   logic         tid_ff;
   logic         room;
   logic         proc_go;
   logic         req_fire;
   push_type     push;
   rsp_item_type out_item;

   assign proc_go    = in_vld_ff && room;
   assign req_tready = !in_vld_ff || proc_go;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_fire) in_vld_in = 1'b1;
      else if (proc_go) in_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         tid_ff    <= 1'b1;
      end else begin
         in_vld_ff <= in_vld_in;
         if (csr_wr_en) tid_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // The parser advances its per-PDU state by one byte each time proc_go is high.
   wspr_parser #(
      .PDU_LENGTH_BITS(PDU_LENGTH_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .tid_present (tid_ff),
      .go          (proc_go),
      .data_byte   (in_data_ff),
      .final_byte  (in_last_ff),
      .push        (push)
   );

   // Result beats wait here until the downstream side takes them.
   wspr_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_ready (rsp_tready),
      .out_vld   (rsp_tvalid),
      .out_item  (out_item),
      .room      (room)
   );

   assign rsp_tdata = {4'd0, out_item.error_code, out_item.headers_truncated,
                       out_item.body_length, out_item.string_end, out_item.value};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.pdu_end;

`ifndef SYNTH
   // The last beat of a PDU is always a done or an error beat.
   a_end_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser == KIND_DONE || rsp_tuser == KIND_ERROR))
      else $error("pdu_end on a beat that is neither done nor error");

   // Error codes appear only on error beats.
   a_err_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != KIND_ERROR) |-> (rsp_tdata[51:50] == ERR_NONE))
      else $error("error code on a non-error beat");

   // A byte held for lack of queue room is not lost.
   a_hold_byte: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !proc_go) |=> in_vld_ff)
      else $error("held input byte dropped");
`endif

endmodule
